### rtl/core/p4nn_pkg.sv
// ----------------------------------------------------------------------------
// p4nn_pkg
// shared types and constants for the top-4 nearest patch search
// ----------------------------------------------------------------------------
`default_nettype none

package p4nn_pkg;

    localparam int PATCH_ROWS_DEF  = 8;
    localparam int KEEP_COUNT_DEF  = 4;
    localparam int INDEX_WIDTH_DEF = 24;

    localparam int LANES  = 8;
    localparam int PIX_W  = 8;
    localparam int SQ_W   = 16;
    localparam int DIST_W = 22;
    localparam int RANK_W = 2;
    localparam int OIDX_W = 24;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [1:0] CMD_QUERY  = 2'd0;
    localparam logic [1:0] CMD_CAND   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0]       command;
        logic [PIX_W-1:0] pixel_0;
        logic [PIX_W-1:0] pixel_1;
        logic [PIX_W-1:0] pixel_2;
        logic [PIX_W-1:0] pixel_3;
        logic [PIX_W-1:0] pixel_4;
        logic [PIX_W-1:0] pixel_5;
        logic [PIX_W-1:0] pixel_6;
        logic [PIX_W-1:0] pixel_7;
    } t_req;

    typedef struct packed {
        logic              valid_res;
        logic [RANK_W-1:0] rank;
        logic [OIDX_W-1:0] candidate_index;
        logic [DIST_W-1:0] distance;
        logic              last;
    } t_rsp;

    typedef struct packed {
        logic ins;
        logic clr;
    } t_list_ctl;

endpackage

`default_nettype wire

### rtl/core/p4nn_lane.sv
// ----------------------------------------------------------------------------
// p4nn_lane
// one pixel lane: registered squared difference of query and candidate pixel
// ----------------------------------------------------------------------------
`default_nettype none

module p4nn_lane (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [p4nn_pkg::PIX_W-1:0]    i_q,
    input  wire logic [p4nn_pkg::PIX_W-1:0]    i_c,
    output logic      [p4nn_pkg::SQ_W-1:0]     o_sq
);

    localparam int PW = p4nn_pkg::PIX_W;
    localparam int SW = p4nn_pkg::SQ_W;

    logic signed [PW:0]     w_diff;
    logic signed [2*PW+1:0] w_prod;
    logic [SW-1:0]          r_sq;

    assign w_diff = $signed({1'b0, i_q}) - $signed({1'b0, i_c});
    assign w_prod = w_diff * w_diff;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= w_prod[SW-1:0];
        end
    end

    assign o_sq = r_sq;

endmodule

`default_nettype wire

### rtl/core/p4nn_list.sv
// ----------------------------------------------------------------------------
// p4nn_list
// sorted best-k list with parallel insert, ties keep older entry
// ----------------------------------------------------------------------------
`default_nettype none

module p4nn_list #(
    parameter int KEEP_COUNT = p4nn_pkg::KEEP_COUNT_DEF,
    parameter int IDX_W      = p4nn_pkg::INDEX_WIDTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire p4nn_pkg::t_list_ctl                   i_ctl,
    input  wire logic [p4nn_pkg::DIST_W-1:0]           i_dist,
    input  wire logic [IDX_W-1:0]                      i_idx,
    input  wire logic [((KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1)-1:0] i_rd,
    output logic      [$clog2(KEEP_COUNT+1)-1:0]       o_count,
    output logic      [p4nn_pkg::DIST_W-1:0]           o_rd_dist,
    output logic      [IDX_W-1:0]                      o_rd_idx
);

    localparam int DW    = p4nn_pkg::DIST_W;
    localparam int CNT_W = $clog2(KEEP_COUNT + 1);

    logic [DW-1:0]         r_dist [KEEP_COUNT];
    logic [IDX_W-1:0]      r_idx  [KEEP_COUNT];
    logic [CNT_W-1:0]      r_count;
    logic [KEEP_COUNT-1:0] w_le;

    // w_le is a thermometer: entries that stay ahead of the new one
    for (genvar k = 0; k < KEEP_COUNT; k++) begin : g_slot
        assign w_le[k] = (CNT_W'(k) < r_count) && (r_dist[k] <= i_dist);

        if (k == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_ctl.ins && !w_le[0]) begin
                    r_dist[0] <= i_dist;
                    r_idx[0]  <= i_idx;
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (i_ctl.ins && !w_le[k]) begin
                    if (w_le[k-1]) begin
                        r_dist[k] <= i_dist;
                        r_idx[k]  <= i_idx;
                    end else begin
                        r_dist[k] <= r_dist[k-1];
                        r_idx[k]  <= r_idx[k-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.clr) begin
            r_count <= '0;
        end else if (i_ctl.ins && (r_count < CNT_W'(KEEP_COUNT))) begin
            r_count <= r_count + 1'b1;
        end
    end

    assign o_count   = r_count;
    assign o_rd_dist = r_dist[i_rd];
    assign o_rd_idx  = r_idx[i_rd];

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(KEEP_COUNT))
        else $error("list count beyond capacity");

    a_full_stays : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.ins && !i_ctl.clr && r_count == CNT_W'(KEEP_COUNT))
        |=> (r_count == CNT_W'(KEEP_COUNT)))
        else $error("full list lost an entry on insert");

endmodule

`default_nettype wire

### rtl/core/patch_top4_nearest_by_ssd_top.sv
// ----------------------------------------------------------------------------
// patch_top4_nearest_by_ssd_top
// top-4 nearest patch search by sum of squared differences
//
//   channel   valid     stall     payload   direction
//   request   i_valid   o_stall   i_req     in
//   result    o_valid   i_stall   o_rsp     out
//
// query load row: stored on acceptance; candidate row: 8 lanes, then sum stage,
// then the list insert stage on the row that completes a candidate
// finish: one result emitted per cycle, held back while i_stall holds
// one request in flight at a time, o_stall is high until it is done
// reset clears control and the list count at once, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module patch_top4_nearest_by_ssd_top #(
    parameter int PATCH_ROWS  = p4nn_pkg::PATCH_ROWS_DEF,
    parameter int KEEP_COUNT  = p4nn_pkg::KEEP_COUNT_DEF,
    parameter int INDEX_WIDTH = p4nn_pkg::INDEX_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire p4nn_pkg::t_req i_req,
    output logic                o_valid,
    input  wire logic           i_stall,
    output p4nn_pkg::t_rsp      o_rsp
);

    localparam int LANES  = p4nn_pkg::LANES;
    localparam int PW     = p4nn_pkg::PIX_W;
    localparam int SW     = p4nn_pkg::SQ_W;
    localparam int DW     = p4nn_pkg::DIST_W;
    localparam int RANK_W = p4nn_pkg::RANK_W;
    localparam int OIDX_W = p4nn_pkg::OIDX_W;
    localparam int ROW_W  = (PATCH_ROWS > 1) ? $clog2(PATCH_ROWS) : 1;
    localparam int K_W    = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam int CNT_KW = $clog2(KEEP_COUNT + 1);
    localparam int CC_W   = INDEX_WIDTH + 1;
    localparam int TREE_W = SW + $clog2(LANES);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUM  = 4'b0010,
        ST_INS  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state                    r_state;
    logic [ROW_W-1:0]          r_row;
    logic [DW-1:0]             r_run;
    logic [CC_W-1:0]           r_cnt;
    logic [K_W-1:0]            r_k;
    logic                      r_endrow;
    logic [DW-1:0]             r_cand_dist;
    logic [INDEX_WIDTH-1:0]    r_cand_idx;
    logic [LANES*PW-1:0]       r_query [PATCH_ROWS];

    logic                      w_acc;
    logic                      w_out_acc;
    logic                      w_lane_en;
    logic [ROW_W-1:0]          n_row;
    logic [LANES*PW-1:0]       w_qrow;
    logic [LANES*PW-1:0]       w_crow;
    logic [SW-1:0]             w_sq [LANES];
    logic [TREE_W-1:0]         w_tree;
    logic [DW:0]               w_full;
    logic [DW-1:0]             n_run;
    p4nn_pkg::t_list_ctl       w_ctl;
    logic [CNT_KW-1:0]         w_count;
    logic [DW-1:0]             w_rd_dist;
    logic [INDEX_WIDTH-1:0]    w_rd_idx;
    logic                      w_last;

    assign o_stall   = (r_state != ST_IDLE);
    assign o_valid   = (r_state == ST_EMIT);
    assign w_acc     = i_valid && (r_state == ST_IDLE);
    assign w_out_acc = o_valid && !i_stall;
    assign w_lane_en = w_acc && (i_req.command == p4nn_pkg::CMD_CAND);

    assign n_row  = (r_row == ROW_W'(PATCH_ROWS - 1)) ? '0 : r_row + 1'b1;
    assign w_qrow = r_query[r_row];
    assign w_crow = {i_req.pixel_7, i_req.pixel_6, i_req.pixel_5, i_req.pixel_4,
                     i_req.pixel_3, i_req.pixel_2, i_req.pixel_1, i_req.pixel_0};

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        p4nn_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_lane_en),
            .i_q   (w_qrow[PW*j +: PW]),
            .i_c   (w_crow[PW*j +: PW]),
            .o_sq  (w_sq[j])
        );
    end

    // merge of the lane results into the running sum
    always_comb begin
        w_tree = '0;
        for (int j = 0; j < LANES; j++) begin
            w_tree = w_tree + TREE_W'(w_sq[j]);
        end
    end

    assign w_full = {1'b0, r_run} + (DW + 1)'(w_tree);
    assign n_run  = w_full[DW] ? p4nn_pkg::DIST_MAX : w_full[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_req.command == p4nn_pkg::CMD_QUERY)) begin
            r_query[r_row] <= w_crow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SUM) begin
            r_cand_dist <= n_run;
            r_cand_idx  <= r_cnt[INDEX_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_row    <= '0;
            r_run    <= '0;
            r_cnt    <= '0;
            r_k      <= '0;
            r_endrow <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        case (i_req.command)
                            p4nn_pkg::CMD_QUERY: begin
                                r_row <= n_row;
                            end
                            p4nn_pkg::CMD_CAND: begin
                                r_endrow <= (r_row == ROW_W'(PATCH_ROWS - 1));
                                r_row    <= n_row;
                                r_state  <= ST_SUM;
                            end
                            p4nn_pkg::CMD_FINISH: begin
                                r_row   <= '0;
                                r_run   <= '0;
                                r_cnt   <= '0;
                                r_k     <= '0;
                                r_state <= ST_EMIT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SUM: begin
                    if (r_endrow) begin
                        r_run <= '0;
                        if (!r_cnt[INDEX_WIDTH]) begin
                            r_cnt   <= r_cnt + 1'b1;
                            r_state <= ST_INS;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_run   <= n_run;
                        r_state <= ST_IDLE;
                    end
                end
                ST_INS: begin
                    r_state <= ST_IDLE;
                end
                ST_EMIT: begin
                    if (w_out_acc) begin
                        if (w_last) begin
                            r_k     <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign w_ctl.ins = (r_state == ST_INS);
    assign w_ctl.clr = w_out_acc && w_last;

    p4nn_list #(
        .KEEP_COUNT (KEEP_COUNT),
        .IDX_W      (INDEX_WIDTH)
    ) u_list (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_dist    (r_cand_dist),
        .i_idx     (r_cand_idx),
        .i_rd      (r_k),
        .o_count   (w_count),
        .o_rd_dist (w_rd_dist),
        .o_rd_idx  (w_rd_idx)
    );

    assign w_last = (w_count == '0) || ((CNT_KW'(r_k) + 1'b1) == w_count);

    always_comb begin
        o_rsp = '0;
        o_rsp.last = w_last;
        if (w_count != '0) begin
            o_rsp.valid_res       = 1'b1;
            o_rsp.rank            = RANK_W'(r_k);
            o_rsp.candidate_index = OIDX_W'(w_rd_idx);
            o_rsp.distance        = w_rd_dist;
        end
    end

    a_emit_index : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |->
        ((w_count == '0 && r_k == '0) || (CNT_KW'(r_k) < w_count)))
        else $error("emit index outside list");

    a_clear_after_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_rsp.last) |=> (w_count == '0 && r_state == ST_IDLE))
        else $error("list not cleared after last result");

    a_mid_row_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM && !r_endrow) |=> (r_state == ST_IDLE))
        else $error("insert started on a row that does not end a candidate");

endmodule

`default_nettype wire

### tb/tb_patch_top4_nearest_by_ssd_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_patch_top4_nearest_by_ssd_top
// The testbench loads query patches and streams candidate patches into the
// block. It works out the four nearest candidates by sum of squared
// differences, and checks every emitted result field by field. It has a
// directed part: empty finish, unused command, and the largest and smallest
// distances. A random part follows with repeated candidates to force ties,
// query rows loaded mid candidate, and partial candidates cut off by finish.
// The sender and the receiver both idle at random.
// ----------------------------------------------------------------------------
module tb_patch_top4_nearest_by_ssd_top;

    localparam int ROWS = p4nn_pkg::PATCH_ROWS_DEF;
    localparam int KEEP = p4nn_pkg::KEEP_COUNT_DEF;
    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam logic [24:0] INDEX_LIMIT = 25'd1 << p4nn_pkg::INDEX_WIDTH_DEF;

    localparam int PIX_FULL    = 0;
    localparam int PIX_EXTREME = 1;
    localparam int PIX_LOW     = 2;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           i_stall = 1'b0;
    p4nn_pkg::t_req i_req   = '0;
    logic           o_stall;
    logic           o_valid;
    p4nn_pkg::t_rsp o_rsp;

    logic [63:0]                 qry_rows [ROWS];
    int                          row_pos = 0;
    int                          ssd_acc = 0;
    logic [24:0]                 cand_num = '0;
    logic [p4nn_pkg::DIST_W-1:0] near_dist [KEEP];
    logic [23:0]                 near_idx [KEEP];
    int                          near_cnt = 0;
    p4nn_pkg::t_rsp              nearest_q [$];

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int req_cnt      = 0;
    int rsp_cnt      = 0;
    int search_cnt   = 0;
    int err_cnt      = 0;

    patch_top4_nearest_by_ssd_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    function automatic p4nn_pkg::t_req pack_row(input logic [1:0] cmd,
                                                input logic [63:0] px);
        p4nn_pkg::t_req r;
        r.command = cmd;
        r.pixel_0 = px[7:0];
        r.pixel_1 = px[15:8];
        r.pixel_2 = px[23:16];
        r.pixel_3 = px[31:24];
        r.pixel_4 = px[39:32];
        r.pixel_5 = px[47:40];
        r.pixel_6 = px[55:48];
        r.pixel_7 = px[63:56];
        return r;
    endfunction

    function automatic int pick_mode();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return PIX_FULL;
        if (roll < 85) return PIX_EXTREME;
        return PIX_LOW;
    endfunction

    function automatic p4nn_pkg::t_req rand_row(input logic [1:0] cmd, input int mode);
        logic [63:0] px;
        int          j;
        for (j = 0; j < 8; j++) begin
            case (mode)
                PIX_EXTREME: px[8*j +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
                PIX_LOW:     px[8*j +: 8] = 8'($urandom_range(2));
                default:     px[8*j +: 8] = 8'($urandom_range(255));
            endcase
        end
        return pack_row(cmd, px);
    endfunction

    function automatic logic [63:0] stripe_row(input int r);
        return (r % 2) ? {64{1'b1}} : 64'd0;
    endfunction

    function automatic void queue_expected(input p4nn_pkg::t_rsp e);
        nearest_q = {nearest_q, e};
    endfunction

    // sorted insert, an equal distance goes behind the entries already held
    function automatic void insert_nearest(input logic [p4nn_pkg::DIST_W-1:0] cand_dist,
                                           input logic [23:0] idx);
        int pos;
        int k;
        pos = 0;
        while (pos < near_cnt && near_dist[pos] <= cand_dist) pos++;
        if (pos < KEEP) begin
            k = (near_cnt < KEEP) ? near_cnt : KEEP - 1;
            while (k > pos) begin
                near_dist[k] = near_dist[k-1];
                near_idx[k]  = near_idx[k-1];
                k--;
            end
            near_dist[pos] = cand_dist;
            near_idx[pos]  = idx;
            if (near_cnt < KEEP) near_cnt++;
        end
    endfunction

    function automatic void predict_req(input p4nn_pkg::t_req r);
        logic [63:0]    px;
        int             acc;
        int             d;
        int             j;
        int             k;
        p4nn_pkg::t_rsp e;
        px = {r.pixel_7, r.pixel_6, r.pixel_5, r.pixel_4,
              r.pixel_3, r.pixel_2, r.pixel_1, r.pixel_0};
        case (r.command)
            p4nn_pkg::CMD_QUERY: begin
                qry_rows[row_pos] = px;
                row_pos = (row_pos + 1) % ROWS;
            end
            p4nn_pkg::CMD_CAND: begin
                acc = ssd_acc;
                for (j = 0; j < 8; j++) begin
                    d = int'(qry_rows[row_pos][8*j +: 8]) - int'(px[8*j +: 8]);
                    acc += d * d;
                end
                ssd_acc = (acc > int'(p4nn_pkg::DIST_MAX)) ? int'(p4nn_pkg::DIST_MAX) : acc;
                if (row_pos == ROWS - 1) begin
                    if (cand_num < INDEX_LIMIT) begin
                        insert_nearest(p4nn_pkg::DIST_W'(ssd_acc), cand_num[23:0]);
                        cand_num++;
                    end
                    ssd_acc = 0;
                end
                row_pos = (row_pos + 1) % ROWS;
            end
            p4nn_pkg::CMD_FINISH: begin
                if (near_cnt == 0) begin
                    e = '0;
                    e.last = 1'b1;
                    queue_expected(e);
                end else begin
                    for (k = 0; k < near_cnt; k++) begin
                        e.valid_res       = 1'b1;
                        e.rank            = p4nn_pkg::RANK_W'(k);
                        e.candidate_index = near_idx[k];
                        e.distance        = near_dist[k];
                        e.last            = (k == near_cnt - 1);
                        queue_expected(e);
                    end
                end
                near_cnt = 0;
                row_pos  = 0;
                ssd_acc  = 0;
                cand_num = '0;
                search_cnt++;
            end
            default: ;
        endcase
    endfunction

    function automatic void cmp_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    function automatic void check_rsp(input p4nn_pkg::t_rsp a);
        p4nn_pkg::t_rsp e;
        rsp_cnt++;
        if (nearest_q.size() == 0) begin
            $error("result with none pending: valid_res %0d rank %0d index %0d distance %0d",
                   a.valid_res, a.rank, a.candidate_index, a.distance);
            err_cnt++;
        end else begin
            e = nearest_q.pop_front();
            cmp_field("valid_res", e.valid_res, a.valid_res);
            cmp_field("rank", e.rank, a.rank);
            cmp_field("candidate_index", e.candidate_index, a.candidate_index);
            cmp_field("distance", e.distance, a.distance);
            cmp_field("last", e.last, a.last);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) predict_req(i_req);
            if (o_valid && !i_stall) check_rsp(o_rsp);
        end
    end

    task automatic send_req(input p4nn_pkg::t_req r);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (r.command != CMD_NOP) req_cnt++;
    endtask

    task automatic test_empty_finish();
        send_req(rand_row(CMD_NOP, PIX_FULL));
        send_req(rand_row(p4nn_pkg::CMD_FINISH, PIX_FULL));
    endtask

    task automatic test_query_load();
        int r;
        for (r = 0; r < ROWS; r++) send_req(pack_row(p4nn_pkg::CMD_QUERY, stripe_row(r)));
    endtask

    task automatic test_extreme_candidates();
        int r;
        for (r = 0; r < ROWS; r++) send_req(pack_row(p4nn_pkg::CMD_CAND, ~stripe_row(r)));
        for (r = 0; r < ROWS; r++) send_req(pack_row(p4nn_pkg::CMD_CAND, stripe_row(r)));
        send_req(rand_row(p4nn_pkg::CMD_FINISH, PIX_FULL));
    endtask

    task automatic run_search();
        p4nn_pkg::t_req tmpl [ROWS];
        int             n_cand;
        int             r;
        int             c;
        int             roll;
        int             mode;
        bit             use_tmpl;
        mode = pick_mode();
        for (r = 0; r < ROWS; r++) tmpl[r] = rand_row(p4nn_pkg::CMD_CAND, mode);
        if ($urandom_range(3) == 0) begin
            for (r = 0; r < ROWS; r++) send_req(rand_row(p4nn_pkg::CMD_QUERY, pick_mode()));
        end
        n_cand = $urandom_range(6, 1);
        for (c = 0; c < n_cand; c++) begin
            use_tmpl = $urandom_range(1);
            mode     = pick_mode();
            for (r = 0; r < ROWS; r++) begin
                roll = $urandom_range(99);
                if (roll < 3) send_req(rand_row(CMD_NOP, PIX_FULL));
                else if (roll < 6) send_req(rand_row(p4nn_pkg::CMD_QUERY, pick_mode()));
                send_req(use_tmpl ? tmpl[r] : rand_row(p4nn_pkg::CMD_CAND, mode));
            end
        end
        // partial candidate dropped by the finish
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(ROWS - 1, 1))
                send_req(rand_row(p4nn_pkg::CMD_CAND, pick_mode()));
        end
        send_req(rand_row(p4nn_pkg::CMD_FINISH, PIX_FULL));
    endtask

    task automatic test_random_phase(input int snd_pct, input int rcv_pct, input int n);
        int start;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        start = req_cnt;
        while (req_cnt - start < n) run_search();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_finish();
        test_query_load();
        test_extreme_candidates();
        test_random_phase(19, 46, 75);
        test_random_phase(46, 19, 75);
        test_random_phase(0, 0, 75);
        i_valid <= 1'b0;
        rcv_idle_pct = 0;
        while (nearest_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("covered %0d requests in %0d searches, %0d results checked",
                 req_cnt, search_cnt, rsp_cnt);
        if (err_cnt == 0) begin
            $display("patch_top4_nearest_by_ssd_top: match");
        end else begin
            $display("patch_top4_nearest_by_ssd_top: mismatch");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("timeout");
        $display("patch_top4_nearest_by_ssd_top: mismatch");
        $finish;
    end

endmodule

### sim.f
rtl/core/p4nn_pkg.sv
rtl/core/p4nn_lane.sv
rtl/core/p4nn_list.sv
rtl/core/patch_top4_nearest_by_ssd_top.sv
tb/tb_patch_top4_nearest_by_ssd_top.sv
